FILE: design/sss_pkg.sv
package sss_pkg;

	// field widths
	localparam int TimeW     = 17;
	localparam int IndexW    = 2;
	localparam int EnableW   = 4;
	localparam int SegW      = 8;
	localparam int PatW      = 7;
	localparam int ScanW     = 4;
	localparam int LimitW    = 12;
	localparam int CfgDataW  = 12;
	localparam int NumDigits = 4;
	localparam int BcdW      = 4;

	// register map
	typedef enum logic [1:0] {
		RegMode         = 2'd0,
		RegScanTicks    = 2'd1,
		RegRefreshLimit = 2'd2,
		RegCommonAnode  = 2'd3
	} cfg_reg_t;

	typedef logic [NumDigits-1:0][BcdW-1:0] bcd_word_t;
	typedef logic [NumDigits-1:0][PatW-1:0] pat_word_t;

	// segments a..g in bits 0..6 for decimal digits
	function automatic logic [PatW-1:0] font7(input logic [BcdW-1:0] d);
		logic [PatW-1:0] p;
		case (d)
			4'd0:    p = 7'h3F;
			4'd1:    p = 7'h06;
			4'd2:    p = 7'h5B;
			4'd3:    p = 7'h4F;
			4'd4:    p = 7'h66;
			4'd5:    p = 7'h6D;
			4'd6:    p = 7'h7D;
			4'd7:    p = 7'h07;
			4'd8:    p = 7'h7F;
			4'd9:    p = 7'h6F;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

FILE: design/sss_if.sv
interface sss_tick_if;
	logic                     valid;
	logic                     ready;
	logic [sss_pkg::TimeW-1:0] time_seconds;

	modport source (output valid, output time_seconds, input ready);
	modport sink   (input valid, input time_seconds, output ready);
endinterface

interface sss_result_if;
	logic                        valid;
	logic                        ready;
	logic [sss_pkg::IndexW-1:0]  digit_index;
	logic [sss_pkg::EnableW-1:0] digit_enable;
	logic [sss_pkg::SegW-1:0]    segment_drive;

	modport source (output valid, output digit_index, output digit_enable,
		output segment_drive, input ready);
	modport sink   (input valid, input digit_index, input digit_enable,
		input segment_drive, output ready);
endinterface

interface sss_cfg_if;
	logic                         valid;
	logic                         ready;
	sss_pkg::cfg_reg_t            reg_index;
	logic [sss_pkg::CfgDataW-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/seven_segment_four_digit_scanner.sv
// four-digit multiplexed seven-segment scanner
//
// tick channel: one word per millisecond tick, carrying the time of day in
// seconds (only shown in mm:ss mode). result channel: one word per scan step,
// giving the digit index, its common-line enable and its segment pattern, both
// at pin level for the selected display polarity. ticks between scan steps
// give no result word.
// cfg channel: always ready, register index plus data; write only while idle.
//
// path: a tick accepted into the input register passes the hour reduction,
// mm:ss digit split and scan/output registers before its result word shows.
// throughput: one tick per cycle; each stage holds one word and moves on as
// soon as the stage after it frees, so ticks keep flowing while a result word
// waits to be taken. only when the output register is full and not taken and
// the waiting tick is a scan step does the chain fill and tick.ready drop.
// reset: config goes to mm:ss, 2 ticks per scan, 1000 ms refresh limit, common
// cathode; counters clear and all four digit patterns are blank.
module seven_segment_four_digit_scanner (
	input  logic clk,
	input  logic arst_n,
	sss_tick_if.sink     tick,
	sss_result_if.source result,
	sss_cfg_if.sink      cfg
);

	localparam logic [16:0] SecPerHour = 17'd3600;

	// configuration registers
	logic                           mode_q;
	logic [sss_pkg::ScanW-1:0]      scan_ticks_q;
	logic [sss_pkg::LimitW-1:0]     refresh_limit_q;
	logic                           common_anode_q;

	// pipeline
	logic                           valid_s1, valid_s2, valid_s3;
	logic [sss_pkg::TimeW-1:0]      time_s1;
	logic [11:0]                    hour_sec_s2;
	sss_pkg::bcd_word_t             digits_s3;
	logic                           adv1, adv2, adv3;

	// scanner state
	logic [sss_pkg::ScanW-1:0]      tick_q;
	logic [sss_pkg::LimitW-1:0]     ms_accum_q;
	logic [sss_pkg::IndexW-1:0]     pos_q;
	sss_pkg::pat_word_t             pat_q;
	sss_pkg::bcd_word_t             secs_q;

	// output register
	logic                           out_valid_q;
	logic [sss_pkg::IndexW-1:0]     out_index_q;
	logic [sss_pkg::EnableW-1:0]    out_enable_q;
	logic [sss_pkg::SegW-1:0]       out_seg_q;

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= 1'b0;
			scan_ticks_q    <= 4'd2;
			refresh_limit_q <= 12'd1000;
			common_anode_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				sss_pkg::RegMode:         mode_q          <= cfg.wdata[0];
				sss_pkg::RegScanTicks:    scan_ticks_q    <= cfg.wdata[sss_pkg::ScanW-1:0];
				sss_pkg::RegRefreshLimit: refresh_limit_q <= cfg.wdata[sss_pkg::LimitW-1:0];
				sss_pkg::RegCommonAnode:  common_anode_q  <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// scan step decision for the word in stage 3
	// ---------------------------------------------------------------
	logic [sss_pkg::ScanW-1:0] tick_inc;
	logic                      scan;
	logic [12:0]               ms_sum;
	logic                      refresh;

	assign tick_inc = (tick_q == 4'd15) ? tick_q : tick_q + 4'd1;
	assign scan     = (tick_inc >= scan_ticks_q);
	assign ms_sum   = {1'b0, ms_accum_q} + 13'(scan_ticks_q);
	assign refresh  = (ms_sum > {1'b0, refresh_limit_q});

	// elastic stage control: a stage moves on when the next one is empty or
	// moving; a non-scan tick leaves stage 3 without needing the output
	assign adv3 = valid_s3 && (!scan || !out_valid_q || result.ready);
	assign adv2 = valid_s2 && (!valid_s3 || adv3);
	assign adv1 = valid_s1 && (!valid_s2 || adv2);
	assign tick.ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (tick.ready)
				valid_s1 <= tick.valid;
			if (!valid_s2 || adv2)
				valid_s2 <= adv1;
			if (!valid_s3 || adv3)
				valid_s3 <= adv2;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready)
			time_s1 <= tick.time_seconds;
	end

	// ---------------------------------------------------------------
	// stage 1 -> 2: seconds modulo one hour, restoring reduction by
	// 3600 * 32 down to 3600 (quotient is at most 36)
	// ---------------------------------------------------------------
	logic [16:0] hour_rem;

	always_comb begin
		hour_rem = time_s1;
		for (int k = 5; k >= 0; k--) begin
			if (hour_rem >= 17'(SecPerHour << k))
				hour_rem = hour_rem - 17'(SecPerHour << k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1)
			hour_sec_s2 <= hour_rem[11:0];
	end

	// ---------------------------------------------------------------
	// stage 2 -> 3: split into mm and ss, then into decimal digits
	// ---------------------------------------------------------------
	logic [26:0] mm_prod;
	logic [5:0]  mm, ss;
	logic [11:0] mm_times60;
	logic [3:0]  mm_tens, ss_tens;

	// tens of a value below 60 by plain compares
	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd50)      t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	always_comb begin
		// floor(t / 60) via 2^20 / 60 reciprocal, exact for t < 3600
		mm_prod    = 27'(hour_sec_s2) * 27'd17477;
		mm         = mm_prod[25:20];
		mm_times60 = {mm, 6'b0} - {4'b0, mm, 2'b0};
		ss         = 6'(hour_sec_s2 - mm_times60);
		mm_tens    = tens_of(mm);
		ss_tens    = tens_of(ss);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			digits_s3[0] <= 4'(ss - {ss_tens[2:0], 3'b0} - {1'b0, ss_tens[2:0], 1'b0});
			digits_s3[1] <= ss_tens;
			digits_s3[2] <= 4'(mm - {mm_tens[2:0], 3'b0} - {1'b0, mm_tens[2:0], 1'b0});
			digits_s3[3] <= mm_tens;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: scanner state, refresh and pin drive
	// ---------------------------------------------------------------
	sss_pkg::bcd_word_t secs_inc;
	sss_pkg::bcd_word_t shown;
	sss_pkg::pat_word_t new_pat;
	logic [sss_pkg::PatW-1:0]    pat_sel;
	logic [sss_pkg::EnableW-1:0] en_onehot;
	logic                        carry;

	// decimal counter increment, wraps 9999 to 0000
	always_comb begin
		carry = 1'b1;
		for (int i = 0; i < sss_pkg::NumDigits; i++) begin
			if (carry && secs_q[i] == 4'd9) begin
				secs_inc[i] = 4'd0;
			end else begin
				secs_inc[i] = secs_q[i] + 4'(carry);
				carry       = 1'b0;
			end
		end
	end

	always_comb begin
		shown = mode_q ? secs_inc : digits_s3;
		for (int i = 0; i < sss_pkg::NumDigits; i++)
			new_pat[i] = sss_pkg::font7(shown[i]);
		pat_sel   = refresh ? new_pat[pos_q] : pat_q[pos_q];
		en_onehot = sss_pkg::EnableW'(1) << pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			ms_accum_q <= '0;
			pos_q      <= '0;
			pat_q      <= '0;
			secs_q     <= '0;
		end else if (adv3) begin
			if (!scan) begin
				tick_q <= tick_inc;
			end else begin
				tick_q <= '0;
				pos_q  <= pos_q + 2'd1;
				if (refresh) begin
					ms_accum_q <= '0;
					pat_q      <= new_pat;
					if (mode_q)
						secs_q <= secs_inc;
				end else begin
					ms_accum_q <= ms_sum[11:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv3 && scan)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	// common cathode: selected line low, lit segment high, dp low
	// common anode: selected line high, lit segment low, dp high
	always_ff @(posedge clk) begin
		if (adv3 && scan) begin
			out_index_q  <= pos_q;
			out_enable_q <= common_anode_q ? en_onehot : ~en_onehot;
			out_seg_q    <= common_anode_q ? ~{1'b0, pat_sel} : {1'b0, pat_sel};
		end
	end

	assign result.valid         = out_valid_q;
	assign result.digit_index   = out_index_q;
	assign result.digit_enable  = out_enable_q;
	assign result.segment_drive = out_seg_q;

endmodule

FILE: design/sss_checker.sv
module sss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tick_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_index,
	input logic [3:0] res_enable,
	input logic [7:0] res_seg
);

	logic       seen_q;
	logic [1:0] last_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_index_q <= '0;
		end else if (res_valid && res_ready) begin
			seen_q       <= 1'b1;
			last_index_q <= res_index;
		end
	end

	// digits are delivered in rotation starting at the rightmost one
	a_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |->
			((!seen_q && res_index == 2'd0) || (seen_q && res_index == last_index_q + 2'd1)))
		else $error("digit index out of rotation");

	// enable selects exactly the indexed digit with dp unlit for the same polarity
	a_pin_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(($onehot(res_enable) && res_enable[res_index] && res_seg[7]) ||
			 ($onehot(~res_enable) && !res_enable[res_index] && !res_seg[7])))
		else $error("digit enable and segment polarity disagree");

	// ticks are refused only while a result word is held up
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> (res_valid && !res_ready))
		else $error("tick refused without a stalled result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable(res_index) && $stable(res_enable) && $stable(res_seg)))
		else $error("stalled result word changed");

endmodule

bind seven_segment_four_digit_scanner sss_checker u_sss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_ready (tick.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_index  (result.digit_index),
	.res_enable (result.digit_enable),
	.res_seg    (result.segment_drive)
);
